// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
// Expects signals clk and rst in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// holds at every clock edge out of reset
`define SPTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define SPTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPTB_ASSERT(label, prop, msg)
`define SPTB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/sptb_pkg.sv =====
// Types and constants for the slicing postfix to B*-tree converter.
// No dependencies; used by every module of the block.
package sptb_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int DEPTH_W    = 9;   // holds 0 .. MAX_BLOCKS
  localparam int RQ_DEPTH   = 4;
  localparam int RQ_PTR_W   = 2;
  localparam int RQ_CNT_W   = 3;
  localparam logic [8:0] BLOCK_COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_STAR    = 2'd1,
    OP_PLUS    = 2'd2,
    OP_INVALID = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_LEAF   = 2'd0,
    KIND_PARENT = 2'd1,
    KIND_LEFT   = 2'd2,
    KIND_RIGHT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_OP    = 2'd1,
    ERR_UNDER = 2'd2,
    ERR_OVER  = 2'd3
  } err_t;

  localparam logic signed [9:0] UNDEF_LINK = -10'sd1;

  typedef struct packed {
    logic [7:0]  bl;
    logic [7:0]  tl;
    logic [7:0]  r;
    logic [31:0] w;
  } cluster_t;

  typedef struct packed {
    logic push;
    logic merge;
  } shift_t;

  typedef struct packed {
    logic [8:0]        node;
    kind_t             kind;
    logic signed [9:0] value;
    err_t              err;
    logic              last;
  } result_t;

endpackage

// ===== hdl/sptb_cell.sv =====
// One stack cell of the cluster stack: a shift-register stage.
// Depends on sptb_pkg.
module sptb_cell (
  input  logic              clk,
  input  sptb_pkg::shift_t  ctrl,
  input  sptb_pkg::cluster_t push_in,
  input  sptb_pkg::cluster_t merge_in,
  output sptb_pkg::cluster_t q
);

  // push: take the entry from above; merge: close the gap from below
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= push_in;
    end else if (ctrl.merge) begin
      q <= merge_in;
    end
  end

endmodule

// ===== hdl/sptb_result_q.sv =====
// Four-entry result queue; takes up to three results per beat, gives one.
// Depends on sptb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sptb_result_q (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  sptb_pkg::result_t   items [3],
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output sptb_pkg::result_t   head
);

  sptb_pkg::result_t mem [sptb_pkg::RQ_DEPTH];
  logic [sptb_pkg::RQ_PTR_W-1:0] wp;
  logic [sptb_pkg::RQ_PTR_W-1:0] rp;
  logic [sptb_pkg::RQ_CNT_W-1:0] count;
  logic pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rp];
  // three free slots whatever the output side does
  assign room      = (count <= sptb_pkg::RQ_CNT_W'(1));

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(push_n)) begin
        mem[wp + sptb_pkg::RQ_PTR_W'(i)] <= items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + sptb_pkg::RQ_PTR_W'(push_n);
      rp    <= rp + sptb_pkg::RQ_PTR_W'(pop);
      count <= count + sptb_pkg::RQ_CNT_W'(push_n) - sptb_pkg::RQ_CNT_W'(pop);
    end
  end

  `SPTB_ASSERT(a_count_bound, count <= sptb_pkg::RQ_CNT_W'(sptb_pkg::RQ_DEPTH), "queue overfilled")
  `SPTB_ASSERT(a_push_room, (push_n == 2'd0) || (count <= sptb_pkg::RQ_CNT_W'(1)), "push without room")
  `SPTB_ASSERT(a_empty_ptrs, (count != '0) || (wp == rp), "pointers disagree when empty")

endmodule

// ===== hdl/slicing_postfix_to_bstar_tree.sv =====
// Top level of the slicing postfix to B*-tree link converter.
// Depends on sptb_pkg, sptb_cell, sptb_result_q and assert_macros.svh.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid/in_stall, operation, block_id,    | in
//           | block_width, last_token                    |
//   output  | out_valid/out_stall, node, link_kind,      | out
//           | link_value, error_code, last_result        |
//   config  | cfg_we, cfg_wdata (block_count)            | in
//
// A token is decoded in the cycle it is accepted; its one to three link
// results enter a four-entry queue and leave at one per cycle while out_stall
// is low; the single output beat limits how fast tokens are taken.
// The cluster stack is a row of 256 shift cells, top of stack in cell 0.
// Synchronous reset clears depth, first-token state and the queue; stack
// cells carry no reset. in_stall rises while the queue holds two or more
// results; out_stall simply holds the queue head.
`include "assert_macros.svh"
module slicing_postfix_to_bstar_tree (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [7:0]         block_id,
  input  logic [31:0]        block_width,
  input  logic               last_token,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         node,
  output logic [1:0]         link_kind,
  output logic signed [9:0]  link_value,
  output logic [1:0]         error_code,
  output logic               last_result
);

  localparam int N = sptb_pkg::MAX_BLOCKS;

  logic [8:0]                   block_count;
  logic [sptb_pkg::DEPTH_W-1:0] depth;
  logic [sptb_pkg::DEPTH_W-1:0] depth_next;
  logic [7:0]                   first_block;
  logic                         first_seen;

  sptb_pkg::cluster_t cell_q [N];
  sptb_pkg::cluster_t leaf;
  sptb_pkg::cluster_t merged;
  sptb_pkg::cluster_t top;
  sptb_pkg::cluster_t below;
  sptb_pkg::shift_t   shift;

  sptb_pkg::op_t     op;
  sptb_pkg::result_t res [3];
  sptb_pkg::result_t head;
  logic [1:0]        push_n;
  logic              room;
  logic              accept;
  logic              do_push;
  logic              do_merge;
  logic              is_cut;
  logic [32:0]       wsum;
  logic [7:0]        root_target;

  assign in_stall = !room;
  assign accept   = in_valid && !in_stall;
  assign op       = sptb_pkg::op_t'(operation);
  assign top      = cell_q[0];
  assign below    = cell_q[1];
  assign is_cut   = (op == sptb_pkg::OP_STAR) || (op == sptb_pkg::OP_PLUS);

  assign do_push  = (op == sptb_pkg::OP_BLOCK) &&
                    (depth != sptb_pkg::DEPTH_W'(sptb_pkg::MAX_BLOCKS));
  assign do_merge = is_cut && (depth >= sptb_pkg::DEPTH_W'(2));

  // new clusters: a leaf for an operand, the joined pair for a cut
  assign leaf = '{bl: block_id, tl: block_id, r: block_id, w: block_width};
  assign wsum = {1'b0, below.w} + {1'b0, top.w};

  always_comb begin
    merged    = below;
    merged.bl = below.bl;
    if (op == sptb_pkg::OP_STAR) begin
      merged.tl = below.tl;
      merged.r  = top.r;
      merged.w  = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];   // saturate
    end else begin
      merged.tl = top.tl;
      merged.r  = (below.w > top.w) ? below.r : top.r;
      merged.w  = (below.w > top.w) ? below.w : top.w;
    end
  end

  assign shift.push  = accept && do_push;
  assign shift.merge = accept && do_merge;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sptb_pkg::cluster_t push_in;
    sptb_pkg::cluster_t merge_in;
    if (i == 0) begin : g_head
      assign push_in  = leaf;
      assign merge_in = merged;
    end else if (i == N - 1) begin : g_tail
      assign push_in  = cell_q[i-1];
      assign merge_in = cell_q[i];
    end else begin : g_mid
      assign push_in  = cell_q[i-1];
      assign merge_in = cell_q[i+1];
    end
    sptb_cell u_cell (
      .clk      (clk),
      .ctrl     (shift),
      .push_in  (push_in),
      .merge_in (merge_in),
      .q        (cell_q[i])
    );
  end

  // root link goes to the first token's block, latched now if this is it
  assign root_target = first_seen ? first_block : block_id;

  always_comb begin
    sptb_pkg::result_t err_res;
    sptb_pkg::result_t root_res;
    logic              two;
    err_res  = '{node: 9'd0, kind: sptb_pkg::KIND_LEAF, value: sptb_pkg::UNDEF_LINK,
                 err: sptb_pkg::ERR_OK, last: 1'b0};
    root_res = '{node: block_count, kind: sptb_pkg::KIND_LEFT,
                 value: $signed({2'b00, root_target}), err: sptb_pkg::ERR_OK, last: 1'b0};
    res[0]   = err_res;
    res[1]   = err_res;
    res[2]   = root_res;
    two      = 1'b0;
    case (op)
      sptb_pkg::OP_BLOCK: begin
        if (do_push) begin
          res[0] = '{node: {1'b0, block_id}, kind: sptb_pkg::KIND_LEAF,
                     value: $signed({1'b0, block_count}), err: sptb_pkg::ERR_OK,
                     last: 1'b0};
        end else begin
          res[0].err = sptb_pkg::ERR_OVER;
        end
      end
      sptb_pkg::OP_STAR: begin
        if (do_merge) begin
          two    = 1'b1;
          res[0] = '{node: {1'b0, top.bl}, kind: sptb_pkg::KIND_PARENT,
                     value: $signed({2'b00, below.r}), err: sptb_pkg::ERR_OK, last: 1'b0};
          res[1] = '{node: {1'b0, below.r}, kind: sptb_pkg::KIND_LEFT,
                     value: $signed({2'b00, top.bl}), err: sptb_pkg::ERR_OK, last: 1'b0};
        end else begin
          res[0].err = sptb_pkg::ERR_UNDER;
        end
      end
      sptb_pkg::OP_PLUS: begin
        if (do_merge) begin
          two    = 1'b1;
          res[0] = '{node: {1'b0, top.bl}, kind: sptb_pkg::KIND_PARENT,
                     value: $signed({2'b00, below.tl}), err: sptb_pkg::ERR_OK, last: 1'b0};
          res[1] = '{node: {1'b0, below.tl}, kind: sptb_pkg::KIND_RIGHT,
                     value: $signed({2'b00, top.bl}), err: sptb_pkg::ERR_OK, last: 1'b0};
        end else begin
          res[0].err = sptb_pkg::ERR_UNDER;
        end
      end
      default: begin
        res[0].err = sptb_pkg::ERR_OP;
      end
    endcase
    // pack the root link straight after the token's own results
    if (last_token && !two) begin
      res[1] = root_res;
    end
    if (last_token) begin
      if (two) begin
        res[2].last = 1'b1;
      end else begin
        res[1].last = 1'b1;
      end
    end else if (two) begin
      res[1].last = 1'b1;
    end else begin
      res[0].last = 1'b1;
    end
    push_n = accept ? (2'd1 + {1'b0, two} + {1'b0, last_token}) : 2'd0;
  end

  always_comb begin
    depth_next = depth;
    if (last_token) begin
      depth_next = '0;
    end else if (do_push) begin
      depth_next = depth + sptb_pkg::DEPTH_W'(1);
    end else if (do_merge) begin
      depth_next = depth - sptb_pkg::DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= sptb_pkg::BLOCK_COUNT_RESET;
      depth       <= '0;
      first_block <= '0;
      first_seen  <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      if (accept) begin
        depth       <= depth_next;
        first_block <= root_target;
        first_seen  <= !last_token;
      end
    end
  end

  sptb_result_q u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .items     (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign node        = head.node;
  assign link_kind   = head.kind;
  assign link_value  = head.value;
  assign error_code  = head.err;
  assign last_result = head.last;

  `SPTB_ASSERT(a_depth_bound, depth <= sptb_pkg::DEPTH_W'(sptb_pkg::MAX_BLOCKS), "stack depth beyond capacity")
  `SPTB_ASSERT_NEXT(a_last_clears, accept && last_token, (depth == '0) && !first_seen, "last token did not clear expression state")
  `SPTB_ASSERT_NEXT(a_push_grows, shift.push && !last_token, depth == $past(depth) + sptb_pkg::DEPTH_W'(1), "push did not grow the stack")

endmodule

// ===== tb/bstar_link_tb_pkg.sv =====
// Link tracker for the slicing postfix to B*-tree testbench: mirrors the
// cluster stack and queues the links that each accepted token should write.
// Depends on sptb_pkg for the token, link and error codes.
package bstar_link_tb_pkg;
  import sptb_pkg::*;

  class bstar_link_tracker;
    cluster_t    stack_mirror [MAX_BLOCKS];
    int unsigned depth;
    logic [7:0]  first_blk;
    bit          first_seen;
    logic [8:0]  block_count;
    result_t     pending_links [$];
    int unsigned faults;
    int unsigned tokens_seen;
    int unsigned links_seen;

    function new();
      depth       = 0;
      first_blk   = '0;
      first_seen  = 1'b0;
      block_count = BLOCK_COUNT_RESET;
      faults      = 0;
      tokens_seen = 0;
      links_seen  = 0;
    endfunction

    function void set_block_count(logic [8:0] value);
      block_count = value;
    endfunction

    function int unsigned pending();
      return pending_links.size();
    endfunction

    function result_t mk_link(logic [8:0] node, kind_t kind, logic signed [9:0] value,
                              err_t err);
      result_t r;
      r.node  = node;
      r.kind  = kind;
      r.value = value;
      r.err   = err;
      r.last  = 1'b0;
      return r;
    endfunction

    // one accepted beat on the token channel
    function void take_token(op_t op, logic [7:0] blk, logic [31:0] wid, logic last);
      result_t     made [$];
      result_t     r;
      cluster_t    c;
      cluster_t    t;
      cluster_t    b;
      logic [32:0] sum;
      tokens_seen++;
      if (!first_seen) begin
        first_blk  = blk;
        first_seen = 1'b1;
      end
      case (op)
        OP_BLOCK: begin
          if (depth >= MAX_BLOCKS) begin
            made = {made, mk_link(9'd0, KIND_LEAF, UNDEF_LINK, ERR_OVER)};
          end else begin
            c.bl = blk;
            c.tl = blk;
            c.r  = blk;
            c.w  = wid;
            stack_mirror[depth] = c;
            depth++;
            made = {made, mk_link({1'b0, blk}, KIND_LEAF, {1'b0, block_count}, ERR_OK)};
          end
        end
        OP_STAR, OP_PLUS: begin
          if (depth < 2) begin
            made = {made, mk_link(9'd0, KIND_LEAF, UNDEF_LINK, ERR_UNDER)};
          end else begin
            t    = stack_mirror[depth - 1];
            b    = stack_mirror[depth - 2];
            c.bl = b.bl;
            if (op == OP_STAR) begin
              sum  = {1'b0, b.w} + {1'b0, t.w};
              c.tl = b.tl;
              c.r  = t.r;
              c.w  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              made = {made, mk_link({1'b0, t.bl}, KIND_PARENT, {2'b00, b.r}, ERR_OK)};
              made = {made, mk_link({1'b0, b.r}, KIND_LEFT, {2'b00, t.bl}, ERR_OK)};
            end else begin
              c.tl = t.tl;
              c.r  = (b.w > t.w) ? b.r : t.r;
              c.w  = (b.w > t.w) ? b.w : t.w;
              made = {made, mk_link({1'b0, t.bl}, KIND_PARENT, {2'b00, b.tl}, ERR_OK)};
              made = {made, mk_link({1'b0, b.tl}, KIND_RIGHT, {2'b00, t.bl}, ERR_OK)};
            end
            depth--;
            stack_mirror[depth - 1] = c;
          end
        end
        default: begin
          made = {made, mk_link(9'd0, KIND_LEAF, UNDEF_LINK, ERR_OP)};
        end
      endcase
      // root link closes the expression, even after an error
      if (last) begin
        made = {made, mk_link(block_count, KIND_LEFT, {2'b00, first_blk}, ERR_OK)};
        depth      = 0;
        first_seen = 1'b0;
      end
      foreach (made[i]) begin
        r      = made[i];
        r.last = (i == made.size() - 1);
        pending_links = {pending_links, r};
      end
    endfunction

    // one accepted beat on the link channel
    function void check_link(logic [8:0] node, logic [1:0] kind, logic signed [9:0] value,
                             logic [1:0] err, logic last);
      result_t want;
      links_seen++;
      if (pending_links.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("ERROR: link %0d with none pending: node %0d kind %0d value %0d err %0d last %0b",
                   links_seen, node, kind, value, err, last);
        return;
      end
      want = pending_links.pop_front();
      if (node !== want.node || kind !== want.kind || value !== want.value ||
          err !== want.err || last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("ERROR: link %0d expected node %0d kind %0d value %0d err %0d last %0b",
                   links_seen, want.node, want.kind, want.value, want.err, want.last);
          $display("       got              node %0d kind %0d value %0d err %0d last %0b",
                   node, kind, value, err, last);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for slicing_postfix_to_bstar_tree: drives postfix tokens
// with random gaps and stalls and checks every link beat against the tracker.
// Depends on sptb_pkg, bstar_link_tb_pkg and the converter RTL.
module tb_top;
  import sptb_pkg::*;
  import bstar_link_tb_pkg::*;

  localparam int HOLD_CYCLES    = 64;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either channel

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [8:0]        cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        operation;
  logic [7:0]        block_id;
  logic [31:0]       block_width;
  logic              last_token;
  logic              out_valid;
  logic              out_stall;
  logic [8:0]        node;
  logic [1:0]        link_kind;
  logic signed [9:0] link_value;
  logic [1:0]        error_code;
  logic              last_result;

  // idle percentages for each side, changed per phase
  int          snd_idle_pct  = 11;
  int          rcv_idle_pct  = 81;
  // hold-off handshake between stimulus and receiver: requests vs. served
  int          hold_requests = 0;
  int          hold_served   = 0;
  int unsigned settings      = 0;
  int unsigned quiet_cycles  = 0;

  bstar_link_tracker links = new();

  slicing_postfix_to_bstar_tree uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .block_id   (block_id),
    .block_width(block_width),
    .last_token (last_token),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .node       (node),
    .link_kind  (link_kind),
    .link_value (link_value),
    .error_code (error_code),
    .last_result(last_result)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls at rcv_idle_pct, or a long hold-off when the
  // stimulus asks for one. The hold-off is counted here so the sender keeps
  // offering tokens meanwhile and the result queue fills up.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // Monitor: values are read at the edge before any NBA lands, so both
  // channels see exactly what the DUT saw. The token is noted before the
  // link check in case a link ever comes out in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        links.take_token(op_t'(operation), block_id, block_width, last_token);
      if (out_valid && !out_stall)
        links.check_link(node, link_kind, link_value, error_code, last_result);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: watchdog, no beat for %0d cycles, %0d links pending",
                 quiet_cycles, links.pending());
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one token and return at the edge it is taken. Random idle cycles
  // go in front, so gaps land after any kind of token.
  task automatic send_token(op_t op, logic [7:0] blk, logic [31:0] wid, logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    block_id    <= blk;
    block_width <= wid;
    last_token  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender goes quiet until every predicted link has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (links.pending() != 0);
  endtask

  // Only called once drained, so the block is idle.
  task automatic write_block_count(logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    links.set_block_count(value);
    settings++;
  endtask

  // Widths biased towards zero, all-ones, a few repeated values (plus-cut
  // ties) and large values whose sums saturate.
  function automatic logic [31:0] rand_width();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 3) << 16;
      3:       return 32'h8000_0000 | $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed expressions with random content; about one in seven
  // is a burst of noise: bad operators, early cuts and stray last marks.
  task automatic run_random(int unsigned count);
    int unsigned target;
    int unsigned left;
    int unsigned depth;
    bit          cut;
    target = links.tokens_seen + count;
    while (links.tokens_seen < target) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4))
          send_token(op_t'($urandom_range(0, 3)), 8'($urandom), rand_width(),
                     $urandom_range(0, 3) == 0);
      end else begin
        left  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        depth = 0;
        while (left != 0 || depth > 1) begin
          cut = (depth >= 2) && (left == 0 || $urandom_range(0, 1) == 1);
          if (cut) begin
            depth--;
            send_token($urandom_range(0, 1) ? OP_STAR : OP_PLUS, 8'($urandom), rand_width(),
                       left == 0 && depth == 1);
          end else begin
            left--;
            depth++;
            send_token(OP_BLOCK, 8'($urandom), rand_width(), left == 0 && depth == 1);
          end
        end
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    operation   <= OP_BLOCK;
    block_id    <= '0;
    block_width <= '0;
    last_token  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed, block_count left at its reset value ----
    // single-block expression: leaf plus root link
    send_token(OP_BLOCK, 8'd0, 32'h0, 1'b1);
    // star with saturating width sum, then plus over the result
    send_token(OP_BLOCK, 8'd255, 32'hFFFF_FFFF, 1'b0);
    send_token(OP_BLOCK, 8'd1, 32'h0000_0001, 1'b0);
    send_token(OP_STAR, 8'd0, 32'h0, 1'b0);
    send_token(OP_BLOCK, 8'd7, 32'h0001_0000, 1'b0);
    send_token(OP_PLUS, 8'd0, 32'h0, 1'b1);
    // plus tie picks the top cluster's right block; the star shows which
    send_token(OP_BLOCK, 8'd3, 32'h0002_0000, 1'b0);
    send_token(OP_BLOCK, 8'd4, 32'h0002_0000, 1'b0);
    send_token(OP_PLUS, 8'd0, 32'h0, 1'b0);
    send_token(OP_BLOCK, 8'd5, 32'h0003_0000, 1'b0);
    send_token(OP_STAR, 8'd0, 32'h0, 1'b1);
    // wider bottom keeps its own right block
    send_token(OP_BLOCK, 8'd6, 32'h0001_0000, 1'b0);
    send_token(OP_BLOCK, 8'd9, 32'h0, 1'b0);
    send_token(OP_PLUS, 8'd0, 32'h0, 1'b0);
    send_token(OP_BLOCK, 8'd8, 32'h0, 1'b0);
    send_token(OP_STAR, 8'd0, 32'h0, 1'b1);
    // error cases; an operator as first token still latches its block field
    send_token(OP_INVALID, 8'd200, 32'h0, 1'b0);
    send_token(OP_STAR, 8'd0, 32'h0, 1'b0);
    send_token(OP_BLOCK, 8'd10, 32'h1234_5678, 1'b0);
    send_token(OP_PLUS, 8'd0, 32'h0, 1'b0);
    send_token(OP_INVALID, 8'd0, 32'h0, 1'b1);
    // underflow on the last token still closes the expression
    send_token(OP_STAR, 8'd77, 32'h0, 1'b1);

    // ---- full stack then overflow, with a long receiver hold-off ----
    wait_drained();
    write_block_count(9'd1);
    for (int i = 0; i <= MAX_BLOCKS; i++) begin
      if (i == 32)
        hold_requests++;
      send_token(OP_BLOCK, 8'(i), rand_width(), i == MAX_BLOCKS);
    end

    // ---- random: sender rarely idle, receiver mostly stalled ----
    wait_drained();
    write_block_count(9'($urandom_range(2, 255)));
    run_random(12);

    // ---- random: the other way round ----
    wait_drained();
    snd_idle_pct = 81;
    rcv_idle_pct = 11;
    write_block_count(9'd256);
    run_random(12);

    // ---- random: no idling on either side ----
    wait_drained();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_block_count(9'd255);
    run_random(6);
    wait_drained();
    write_block_count(9'd1);
    run_random(6);

    wait_drained();
    repeat (16) @(posedge clk);
    if (links.pending() != 0)
      $display("ERROR: %0d links never came out", links.pending());
    $display("Run covered %0d tokens and %0d links over %0d block_count settings,",
             links.tokens_seen, links.links_seen, settings + 1);
    $display("with both cuts, saturation, plus ties, underflow, overflow and bad operators.");
    if (links.faults == 0 && links.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
